@@ rtl/lerp_pkg.sv @@
// Shared types and constants for the loop event recorder and player.
// Holds request and result codes, register indexes, reset values and the entry layout.
// No dependencies.
package lerp_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned IDX8_W = 8;
  localparam int unsigned BEAT_W = 17;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CFG_A_W = 3;

  // Request codes carried on req_type
  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_RECORD  = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_RESTART = 2'd3
  } req_e_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_EVENT  = 2'd0,
    KIND_CLICK  = 2'd1,
    KIND_ACCENT = 2'd2
  } kind_e_t;

  // Register indexes on the configuration port
  localparam logic [CFG_A_W-1:0] CFG_LOOP_LEN   = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_BEAT_LEN   = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_PLAY_EN    = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_CLICK_EN   = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_CLICK_SND  = 3'd4;
  localparam logic [CFG_A_W-1:0] CFG_ACCENT_SND = 3'd5;

  // Reset values
  localparam logic [POS_W-1:0]  LOOP_LEN_RST = 16'd2000;
  localparam logic [POS_W-1:0]  BEAT_LEN_RST = 16'd500;
  localparam logic [BEAT_W-1:0] NO_BEAT      = 17'h1FFFF;

  // One stored event
  typedef struct packed {
    logic [POS_W-1:0]  time_ms;
    logic [IDX8_W-1:0] smp;
    logic [IDX8_W-1:0] snd;
    logic              midi;
  } ev_t;

endpackage

@@ rtl/loop_event_recorder_player.sv @@
// Loop event recorder and player with metronome clicks, driven by millisecond ticks.
// Depends on lerp_pkg (types, codes, reset values); holds the event memory and the
// shared restoring divider used for the position wrap and the beat number.
//
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+-----------------------------------------
// req      | in        | req_valid / req_ready | req_type, sample_index, sound_index, is_midi
// res      | out       | res_valid / res_ready | kind, sample_index_out, sound_index_out,
//          |           |                       | midi_out, last
// cfg      | in        | cfg_we                | cfg_index, cfg_data
//
// Clear and restart are done without leaving the idle state. Record, and a tick while not
// playing, run 16 steps of the shared divider to reduce the position modulo the loop length. A
// tick while playing adds 16 steps of beat division when clicks are on, then scans each stored
// event, then releases the held final event, then a pending click, and then finishes.
// Results found mid-scan do not pause the scan; a stalled result channel holds scan and flush.
// The final result may wait while the next transaction is taken. Reset is synchronous.
module loop_event_recorder_player #(
  parameter int unsigned MAX_EVENTS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [1:0]                        req_type,
  input  logic [lerp_pkg::IDX8_W-1:0]       sample_index,
  input  logic [lerp_pkg::IDX8_W-1:0]       sound_index,
  input  logic                              is_midi,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [1:0]                        kind,
  output logic [lerp_pkg::IDX8_W-1:0]       sample_index_out,
  output logic [lerp_pkg::IDX8_W-1:0]       sound_index_out,
  output logic                              midi_out,
  output logic                              last,
  input  logic                              cfg_we,
  input  logic [lerp_pkg::CFG_A_W-1:0]      cfg_index,
  input  logic [lerp_pkg::CFG_W-1:0]        cfg_data
);

  localparam int unsigned IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_EVENTS + 1);
  localparam int unsigned PW    = lerp_pkg::POS_W;
  localparam int unsigned DC_W  = $clog2(PW);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_EVENTS);
  localparam logic [DC_W-1:0]  DIV_LAST = DC_W'(PW - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOD   = 5'b00010,
    ST_BEAT  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  // Configuration registers
  logic [PW-1:0]                   loop_length_ms;
  logic [PW-1:0]                   beat_length_ms;
  logic                            play_enable;
  logic                            click_enable;
  logic [lerp_pkg::IDX8_W-1:0]     click_sound;
  logic [lerp_pkg::IDX8_W-1:0]     accent_sound;

  // Control and working state
  state_t                          state;
  lerp_pkg::req_e_t                req_q;
  logic [lerp_pkg::IDX8_W-1:0]     smp_q;
  logic [lerp_pkg::IDX8_W-1:0]     snd_q;
  logic                            midi_q;
  logic [PW-1:0]                   loop_position;
  logic [CNT_W-1:0]                event_count;
  logic [lerp_pkg::BEAT_W-1:0]     last_beat;
  logic [PW-1:0]                   cur;
  logic                            click_pend;
  logic                            click_accent;
  logic [CNT_W-1:0]                scan_idx;
  logic                            rd_vld;
  lerp_pkg::ev_t                   rd_data;
  logic                            held_vld;
  logic [lerp_pkg::IDX8_W-1:0]     held_smp;
  logic [lerp_pkg::IDX8_W-1:0]     held_snd;
  logic                            held_midi;

  // Shared divider
  logic [PW-1:0]                   div_rem;
  logic [PW-1:0]                   div_quo;
  logic [PW-1:0]                   div_den;
  logic [DC_W-1:0]                 div_cnt;
  logic [PW:0]                     rem_sh;
  logic                            div_ge;
  logic [PW-1:0]                   rem_new;
  logic [PW-1:0]                   quo_new;
  logic                            div_done;

  // Event memory
  lerp_pkg::ev_t                   mem [MAX_EVENTS];
  logic                            wr_en;
  lerp_pkg::ev_t                   wr_data;
  logic                            rd_en;

  // Misc combinational
  logic [PW-1:0]                   len_eff;
  logic [PW-1:0]                   blen_eff;
  logic                            accept;
  logic                            slot_free;
  logic                            match;
  logic                            scan_stall;
  logic                            scan_more;
  logic [PW-1:0]                   pos_base;
  logic [PW:0]                     pos_inc;
  logic [PW-1:0]                   pos_next;
  logic                            out_load;
  lerp_pkg::kind_e_t               out_kind;
  logic [lerp_pkg::IDX8_W-1:0]     out_smp;
  logic [lerp_pkg::IDX8_W-1:0]     out_snd;
  logic                            out_midi;
  logic                            out_last;

  assign len_eff   = (loop_length_ms == '0) ? PW'(1) : loop_length_ms;
  assign blen_eff  = (beat_length_ms == '0) ? PW'(1) : beat_length_ms;
  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign slot_free = !res_valid || res_ready;

  // One restoring division step
  assign rem_sh   = {div_rem, div_quo[PW-1]};
  assign div_ge   = rem_sh >= {1'b0, div_den};
  assign rem_new  = div_ge ? PW'(rem_sh - {1'b0, div_den}) : rem_sh[PW-1:0];
  assign quo_new  = {div_quo[PW-2:0], div_ge};
  assign div_done = (div_cnt == DIV_LAST);

  // Position after this tick
  assign pos_base = (state == ST_MOD) ? rem_new : cur;
  assign pos_inc  = {1'b0, pos_base} + (PW+1)'(1);
  assign pos_next = (pos_inc >= {1'b0, len_eff}) ? '0 : pos_inc[PW-1:0];

  // Scan control
  assign match      = rd_vld && (rd_data.time_ms == cur);
  assign scan_stall = match && held_vld && !slot_free;
  assign scan_more  = (scan_idx < event_count);
  assign rd_en      = (state == ST_SCAN) && !scan_stall && scan_more;

  // Record write
  assign wr_en   = (state == ST_MOD) && div_done && (req_q == lerp_pkg::REQ_RECORD)
                   && (event_count < MAX_CNT);
  assign wr_data = '{time_ms: rem_new, smp: smp_q, snd: snd_q, midi: midi_q};

  // Pick what goes into the result register
  always_comb begin
    out_load = 1'b0;
    out_kind = lerp_pkg::KIND_EVENT;
    out_smp  = held_smp;
    out_snd  = held_snd;
    out_midi = held_midi;
    out_last = 1'b0;
    case (state)
      ST_SCAN: begin
        out_load = !scan_stall && match && held_vld;
      end
      ST_FLUSH: begin
        if (held_vld) begin
          out_load = slot_free;
          out_last = !click_pend;
        end else if (click_pend) begin
          out_load = slot_free;
          out_kind = click_accent ? lerp_pkg::KIND_ACCENT : lerp_pkg::KIND_CLICK;
          out_smp  = '0;
          out_snd  = click_accent ? accent_sound : click_sound;
          out_midi = 1'b0;
          out_last = 1'b1;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind             <= out_kind;
      sample_index_out <= out_smp;
      sound_index_out  <= out_snd;
      midi_out         <= out_midi;
      last             <= out_last;
    end
  end

  // Event memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[event_count[IDX_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[scan_idx[IDX_W-1:0]];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_length_ms <= lerp_pkg::LOOP_LEN_RST;
      beat_length_ms <= lerp_pkg::BEAT_LEN_RST;
      play_enable    <= 1'b0;
      click_enable   <= 1'b0;
      click_sound    <= '0;
      accent_sound   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lerp_pkg::CFG_LOOP_LEN:   loop_length_ms <= cfg_data;
        lerp_pkg::CFG_BEAT_LEN:   beat_length_ms <= cfg_data;
        lerp_pkg::CFG_PLAY_EN:    play_enable    <= cfg_data[0];
        lerp_pkg::CFG_CLICK_EN:   click_enable   <= cfg_data[0];
        lerp_pkg::CFG_CLICK_SND:  click_sound    <= cfg_data[lerp_pkg::IDX8_W-1:0];
        lerp_pkg::CFG_ACCENT_SND: accent_sound   <= cfg_data[lerp_pkg::IDX8_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= lerp_pkg::req_e_t'(req_type);
      smp_q  <= sample_index;
      snd_q  <= sound_index;
      midi_q <= is_midi;
    end
  end

  // Shared divider datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      div_rem <= '0;
      div_quo <= loop_position;
      div_den <= len_eff;
      div_cnt <= '0;
    end else if ((state == ST_MOD) && div_done) begin
      div_rem <= '0;
      div_quo <= rem_new;
      div_den <= blen_eff;
      div_cnt <= '0;
    end else if ((state == ST_MOD) || (state == ST_BEAT)) begin
      div_rem <= rem_new;
      div_quo <= quo_new;
      div_cnt <= div_cnt + DC_W'(1);
    end
  end

  // Held match: released when the next match arrives or at the end of the scan
  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && !scan_stall && match) begin
      held_smp  <= rd_data.smp;
      held_snd  <= rd_data.snd;
      held_midi <= rd_data.midi;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      loop_position <= '0;
      event_count   <= '0;
      last_beat     <= lerp_pkg::NO_BEAT;
      cur           <= '0;
      click_pend    <= 1'b0;
      click_accent  <= 1'b0;
      scan_idx      <= '0;
      rd_vld        <= 1'b0;
      held_vld      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req_type == lerp_pkg::REQ_CLEAR) begin
              event_count <= '0;
            end else if (req_type == lerp_pkg::REQ_RESTART) begin
              loop_position <= '0;
            end else begin
              state <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          if (div_done) begin
            cur        <= rem_new;
            scan_idx   <= '0;
            rd_vld     <= 1'b0;
            held_vld   <= 1'b0;
            click_pend <= 1'b0;
            if (req_q == lerp_pkg::REQ_RECORD) begin
              if (event_count < MAX_CNT) begin
                event_count <= event_count + CNT_W'(1);
              end
              state <= ST_IDLE;
            end else if (!play_enable) begin
              loop_position <= pos_next;
              state         <= ST_IDLE;
            end else if (click_enable) begin
              state <= ST_BEAT;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_BEAT: begin
          // Click only when the beat number moves on
          if (div_done) begin
            if ({1'b0, quo_new} != last_beat) begin
              last_beat    <= {1'b0, quo_new};
              click_pend   <= 1'b1;
              click_accent <= (quo_new[1:0] == 2'b00);
            end
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!scan_stall) begin
            if (match) begin
              held_vld <= 1'b1;
            end
            if (scan_more) begin
              scan_idx <= scan_idx + CNT_W'(1);
              rd_vld   <= 1'b1;
            end else begin
              rd_vld <= 1'b0;
              state  <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (held_vld) begin
            if (slot_free) begin
              held_vld <= 1'b0;
            end
          end else if (click_pend) begin
            if (slot_free) begin
              click_pend <= 1'b0;
            end
          end else begin
            loop_position <= pos_next;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ dv/loop_event_recorder_player_chk.sv @@
// Checker for the loop event recorder and player: keeps its own copy of the loop,
// the event table and the metronome, and checks every result transaction in order.
// Depends on lerp_pkg for request and result codes, register indexes and the entry layout.
module loop_event_recorder_player_chk #(
  parameter int unsigned MAX_EVENTS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  logic                         req_ready,
  input  logic [1:0]                   req_type,
  input  logic [lerp_pkg::IDX8_W-1:0]  sample_index,
  input  logic [lerp_pkg::IDX8_W-1:0]  sound_index,
  input  logic                         is_midi,
  input  logic                         res_valid,
  input  logic                         res_ready,
  input  logic [1:0]                   kind,
  input  logic [lerp_pkg::IDX8_W-1:0]  sample_index_out,
  input  logic [lerp_pkg::IDX8_W-1:0]  sound_index_out,
  input  logic                         midi_out,
  input  logic                         last,
  input  logic                         cfg_we,
  input  logic [lerp_pkg::CFG_A_W-1:0] cfg_index,
  input  logic [lerp_pkg::CFG_W-1:0]   cfg_data,
  output int                           pending,
  output int                           faults
);

  localparam int REPORT_LIMIT = 10;
  localparam int unsigned PW  = lerp_pkg::POS_W;
  localparam int unsigned SW  = lerp_pkg::IDX8_W;

  // One sound the block is due to play
  typedef struct packed {
    lerp_pkg::kind_e_t kind;
    logic [SW-1:0]     smp;
    logic [SW-1:0]     snd;
    logic              midi;
    logic              last;
  } voice_t;

  // Mirrored registers
  logic [PW-1:0]     loop_len;
  logic [PW-1:0]     beat_len;
  logic              play_en;
  logic              click_en;
  logic [SW-1:0]     click_snd;
  logic [SW-1:0]     accent_snd;

  // Mirrored loop state
  logic [PW-1:0]                 loop_pos;
  lerp_pkg::ev_t                 ev_table [MAX_EVENTS];
  int unsigned                   ev_count;
  logic [lerp_pkg::BEAT_W-1:0]   last_beat;

  // Sounds predicted but not yet seen on the result channel
  voice_t            due_voices [$];

  always @(posedge clk) begin
    logic [PW-1:0]               len;
    logic [PW-1:0]               blen;
    logic [PW-1:0]               cur;
    logic [lerp_pkg::BEAT_W-1:0] beat;
    voice_t                      v;
    voice_t                      head;
    int                          first;
    if (rst) begin
      loop_len   = lerp_pkg::LOOP_LEN_RST;
      beat_len   = lerp_pkg::BEAT_LEN_RST;
      play_en    = 1'b0;
      click_en   = 1'b0;
      click_snd  = '0;
      accent_snd = '0;
      loop_pos   = '0;
      ev_count   = 0;
      last_beat  = lerp_pkg::NO_BEAT;
      faults     = 0;
      due_voices.delete();
    end else begin
      // Compare each result transaction with the oldest outstanding prediction
      if (res_valid && res_ready) begin
        if (due_voices.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT)
            $display("%0t: unexpected result kind %0d smp %02h snd %02h midi %0b last %0b",
                     $time, kind, sample_index_out, sound_index_out, midi_out, last);
        end else begin
          head = due_voices.pop_front();
          if (kind !== head.kind || sample_index_out !== head.smp ||
              sound_index_out !== head.snd || midi_out !== head.midi ||
              last !== head.last) begin
            faults++;
            if (faults <= REPORT_LIMIT)
              $display({"%0t: result mismatch: expected kind %0d smp %02h snd %02h ",
                        "midi %0b last %0b, got kind %0d smp %02h snd %02h midi %0b last %0b"},
                       $time, head.kind, head.smp, head.snd, head.midi, head.last,
                       kind, sample_index_out, sound_index_out, midi_out, last);
          end
        end
      end

      // Work out what each request transaction plays and how it moves the loop
      if (req_valid && req_ready) begin
        len = loop_len;
        if (len == '0)
          len = PW'(1);
        cur = loop_pos % len;
        case (lerp_pkg::req_e_t'(req_type))
          lerp_pkg::REQ_RECORD: begin
            // drop the request when the table is full
            if (ev_count < MAX_EVENTS) begin
              ev_table[ev_count] = '{cur, sample_index, sound_index, is_midi};
              ev_count++;
            end
          end
          lerp_pkg::REQ_CLEAR:   ev_count = 0;
          lerp_pkg::REQ_RESTART: loop_pos = '0;
          default: begin
            if (play_en) begin
              first = due_voices.size();
              for (int i = 0; i < ev_count; i++) begin
                if (ev_table[i].time_ms == cur) begin
                  v = '{lerp_pkg::KIND_EVENT, ev_table[i].smp, ev_table[i].snd,
                        ev_table[i].midi, 1'b0};
                  due_voices.insert(due_voices.size(), v);
                end
              end
              // click only when the beat number changes; every fourth beat is an accent
              if (click_en) begin
                blen = beat_len;
                if (blen == '0)
                  blen = PW'(1);
                beat = {1'b0, cur / blen};
                if (beat != last_beat) begin
                  last_beat = beat;
                  if (beat[1:0] == 2'b00)
                    v = '{lerp_pkg::KIND_ACCENT, '0, accent_snd, 1'b0, 1'b0};
                  else
                    v = '{lerp_pkg::KIND_CLICK, '0, click_snd, 1'b0, 1'b0};
                  due_voices.insert(due_voices.size(), v);
                end
              end
              if (due_voices.size() > first)
                due_voices[due_voices.size() - 1].last = 1'b1;
            end
            // advance the position whether or not playing
            loop_pos = ({1'b0, cur} + 17'd1 >= {1'b0, len}) ? '0 : cur + 1'b1;
          end
        endcase
      end

      // Mirror register writes; unknown indexes are ignored
      if (cfg_we) begin
        case (cfg_index)
          lerp_pkg::CFG_LOOP_LEN:   loop_len   = cfg_data;
          lerp_pkg::CFG_BEAT_LEN:   beat_len   = cfg_data;
          lerp_pkg::CFG_PLAY_EN:    play_en    = cfg_data[0];
          lerp_pkg::CFG_CLICK_EN:   click_en   = cfg_data[0];
          lerp_pkg::CFG_CLICK_SND:  click_snd  = cfg_data[SW-1:0];
          lerp_pkg::CFG_ACCENT_SND: accent_snd = cfg_data[SW-1:0];
          default: ;
        endcase
      end
    end
    pending = due_voices.size();
  end

endmodule

@@ dv/loop_event_recorder_player_tb.sv @@
// Testbench top for the loop event recorder and player: drives requests, register
// writes and result back-pressure, and gives the verdict from the checker's count.
// Depends on lerp_pkg, loop_event_recorder_player and loop_event_recorder_player_chk.
module loop_event_recorder_player_tb;
  import lerp_pkg::*;

  localparam int unsigned MAX_EVENTS   = 32;
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned QUIET_CYCLES = 120;
  localparam longint      LIMIT_TIME   = 8_000_000;
  localparam logic [CFG_A_W-1:0] CFG_SPARE = 3'd7;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_ready;
  logic [1:0]         req_type;
  logic [IDX8_W-1:0]  sample_index;
  logic [IDX8_W-1:0]  sound_index;
  logic               is_midi;
  logic               res_valid;
  logic               res_ready;
  logic [1:0]         kind;
  logic [IDX8_W-1:0]  sample_index_out;
  logic [IDX8_W-1:0]  sound_index_out;
  logic               midi_out;
  logic               last;
  logic               cfg_we;
  logic [CFG_A_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  int pending;
  int faults;
  bit calm;

  loop_event_recorder_player #(.MAX_EVENTS(MAX_EVENTS)) u_top (.*);

  loop_event_recorder_player_chk #(.MAX_EVENTS(MAX_EVENTS)) u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the result channel at random, except in calm stretches
  initial begin
    res_ready <= 1'b0;
    forever begin
      @(negedge clk);
      res_ready <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  // Hand over one request transaction; return at the falling edge after acceptance
  task automatic send_req(input req_e_t rt, input logic [IDX8_W-1:0] smp,
                          input logic [IDX8_W-1:0] snd, input logic midi);
    while (!calm && $urandom_range(0, 99) < 30) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid    <= 1'b1;
    req_type     <= rt;
    sample_index <= smp;
    sound_index  <= snd;
    is_midi      <= midi;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic send_any(input req_e_t rt);
    send_req(rt, IDX8_W'($urandom_range(0, 255)), IDX8_W'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
  endtask

  task automatic tick_n(input int n);
    repeat (n) send_any(REQ_TICK);
  endtask

  task automatic set_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Hold requests back until every predicted result is in, then let the block go idle
  task automatic settle();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned      sent;
    int unsigned      phase;
    int unsigned      r;
    int unsigned      n;
    logic [CFG_W-1:0] junk;
    rst          <= 1'b1;
    req_valid    <= 1'b0;
    req_type     <= REQ_TICK;
    sample_index <= '0;
    sound_index  <= '0;
    is_midi      <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_LOOP_LEN;
    cfg_data     <= '0;
    calm          = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Not playing: ticks give nothing but still advance the position
    tick_n(1);
    send_req(REQ_RECORD, 8'h00, 8'h00, 1'b0);
    send_req(REQ_RECORD, 8'hFF, 8'hFF, 1'b1);
    send_any(REQ_RESTART);
    settle();

    // Short loop, one-millisecond beats: a click on every tick, and the stored events at their position
    set_reg(CFG_LOOP_LEN, 16'd3);
    set_reg(CFG_BEAT_LEN, 16'd1);
    set_reg(CFG_PLAY_EN, 16'd1);
    set_reg(CFG_CLICK_EN, 16'd1);
    set_reg(CFG_CLICK_SND, 16'h00FF);
    set_reg(CFG_ACCENT_SND, 16'h0000);
    set_reg(CFG_SPARE, 16'hFFFF);
    cfg_we <= 1'b0;
    tick_n(6);
    send_any(REQ_CLEAR);
    tick_n(1);
    settle();

    // Clicks off with a zero beat length: the last beat seen must survive
    set_reg(CFG_CLICK_EN, 16'd0);
    set_reg(CFG_BEAT_LEN, 16'd0);
    cfg_we <= 1'b0;
    send_req(REQ_RECORD, 8'hA5, 8'h5A, 1'b1);
    tick_n(2);
    settle();

    // Zero loop length pins the position at zero
    set_reg(CFG_LOOP_LEN, 16'd0);
    set_reg(CFG_CLICK_EN, 16'd1);
    cfg_we <= 1'b0;
    tick_n(1);
    send_req(REQ_RECORD, 8'h3C, 8'hC3, 1'b0);
    tick_n(1);
    settle();

    // Run the position up on a long loop, then shorten the loop beneath it
    set_reg(CFG_LOOP_LEN, 16'hFFFF);
    set_reg(CFG_PLAY_EN, 16'd0);
    cfg_we <= 1'b0;
    tick_n(4);
    settle();
    set_reg(CFG_LOOP_LEN, 16'd3);
    set_reg(CFG_BEAT_LEN, 16'hFFFF);
    set_reg(CFG_PLAY_EN, 16'd1);
    cfg_we <= 1'b0;
    tick_n(1);
    send_any(REQ_RESTART);
    tick_n(1);

    // Random phases, each under a fresh register setting
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      calm = (phase == 3 || phase == 4);
      if (phase % 5 == 2) begin
        // pack the whole table at one position so that a single tick drains it
        set_reg(CFG_LOOP_LEN, 16'd1);
        set_reg(CFG_PLAY_EN, 16'd1);
        set_reg(CFG_CLICK_EN, 16'($urandom_range(0, 1)));
        cfg_we <= 1'b0;
        send_any(REQ_CLEAR);
        repeat (MAX_EVENTS + 2) send_any(REQ_RECORD);
        tick_n(3);
        sent += MAX_EVENTS + 6;
      end else begin
        r = $urandom_range(0, 9);
        set_reg(CFG_LOOP_LEN, (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
                              16'($urandom_range(1, 24)));
        r = $urandom_range(0, 9);
        set_reg(CFG_BEAT_LEN, (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
                              (r == 2) ? 16'd1 : 16'($urandom_range(1, 8)));
        junk = 16'($urandom);
        set_reg(CFG_PLAY_EN, {junk[15:1], 1'($urandom_range(0, 9) != 0)});
        junk = 16'($urandom);
        set_reg(CFG_CLICK_EN, {junk[15:1], 1'($urandom_range(0, 9) < 7)});
        junk = 16'($urandom);
        set_reg(CFG_CLICK_SND, {junk[15:8], 8'($urandom_range(0, 255))});
        junk = 16'($urandom);
        set_reg(CFG_ACCENT_SND, {junk[15:8], 8'($urandom_range(0, 255))});
        if ($urandom_range(0, 3) == 0)
          set_reg(CFG_SPARE, 16'($urandom));
        cfg_we <= 1'b0;
        n = $urandom_range(15, 35);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 22)
            send_any(REQ_RECORD);
          else if (r < 26)
            send_any(REQ_CLEAR);
          else if (r < 30)
            send_any(REQ_RESTART);
          else
            send_any(REQ_TICK);
        end
        sent += n;
      end
      phase++;
    end

    settle();
    if (faults == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Stop a run that hangs
  initial begin
    #LIMIT_TIME;
    $display("TEST FAILED");
    $finish;
  end

endmodule
